// ===== design/assert_macros.svh =====
// Assertion macros used by the grid cell motion detector datapath.
// Each macro expects clk and rst_n to be visible in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, disabled while reset is asserted.
`define GMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle check, disabled while reset is asserted.
`define GMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== design/gmd_pkg.sv =====
// Types and constants for the grid cell motion detector.
// Used by the controller, datapath, divider and top level.
package gmd_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_PREP, ST_DIV1, ST_START2, ST_DIV2, ST_EMIT
  } gmd_state_t;

  // measure_mode codes
  localparam logic [2:0] MEAS_U = 3'd0;
  localparam logic [2:0] MEAS_Y = 3'd1;
  localparam logic [2:0] MEAS_V = 3'd2;
  localparam logic [2:0] MEAS_R = 3'd3;
  localparam logic [2:0] MEAS_G = 3'd4;
  localparam logic [2:0] MEAS_B = 3'd5;

  // region_mode codes
  localparam logic [1:0] REGION_ALL     = 2'd0;
  localparam logic [1:0] REGION_INSIDE  = 2'd1;
  localparam logic [1:0] REGION_OUTSIDE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MEASURE_MODE = 3'd0;
  localparam logic [2:0] REG_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_POINTS       = 3'd2;
  localparam logic [2:0] REG_REGION_MODE  = 3'd3;
  localparam logic [2:0] REG_COL_LO       = 3'd4;
  localparam logic [2:0] REG_COL_HI       = 3'd5;
  localparam logic [2:0] REG_ROW_LO       = 3'd6;
  localparam logic [2:0] REG_ROW_HI       = 3'd7;

  localparam int PTS_W  = 21;
  localparam int CNT_W  = 11;
  localparam int CFG_W  = 21;
  localparam int IDX_W  = 10;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

  // YUV to RGB coefficients, 12-bit fraction
  localparam logic signed [13:0] COEF_RV = 14'sd5743;
  localparam logic signed [13:0] COEF_GU = 14'sd1411;
  localparam logic signed [13:0] COEF_GV = 14'sd2925;
  localparam logic signed [13:0] COEF_BU = 14'sd7258;
  localparam logic signed [24:0] ROUND_HALF = 25'sd2048;
  localparam logic [8:0] CHROMA_OFS = 9'd128;
  localparam logic signed [12:0] PIX_MAX = 13'sd255;

  typedef struct packed {
    logic clr_en;
    logic take;
    logic fetch;
    logic prep;
    logic div_start;
    logic div_sel;
    logic cap_diff;
    logic cap_lvl;
    logic out_load;
  } gmd_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic out_free;
  } gmd_sts_t;

endpackage

// ===== design/gmd_div.sv =====
// Bit-serial restoring divider, unsigned, one quotient bit per cycle.
// Uses gmd_pkg for the divisor width.
module gmd_div
  import gmd_pkg::*;
#(
  parameter int DW = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  input  logic [PTS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DW-1:0]    quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]    dvd_r, dvd_nxt;
  logic [PTS_W-1:0] rem_r, rem_nxt;
  logic [PTS_W-1:0] dsr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [PTS_W+1:0] trial;

  always_comb begin
    trial    = {1'b0, rem_r, dvd_r[DW-1]} - {2'b00, dsr_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // keep the shifted remainder when the trial subtraction borrows
      if (trial[PTS_W+1]) begin
        rem_nxt = {rem_r[PTS_W-2:0], dvd_r[DW-1]};
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      end else begin
        rem_nxt = trial[PTS_W-1:0];
        dvd_nxt = {dvd_r[DW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== design/gmd_ctrl.sv =====
// Controller state machine for the grid cell motion detector.
// Drives gmd_cmd_t commands into the datapath, reads gmd_sts_t back.
module gmd_ctrl
  import gmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_cell_end,
  output logic     in_tready,
  input  gmd_sts_t sts,
  output gmd_cmd_t cmd
);

  gmd_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid && in_cell_end) state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DIV1;
      ST_DIV1:   if (sts.div_done) state_nxt = ST_START2;
      ST_START2: state_nxt = ST_DIV2;
      ST_DIV2:   if (sts.div_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_FETCH: cmd.fetch = 1'b1;
      ST_PREP: begin
        cmd.prep      = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIV1: cmd.cap_diff = sts.div_done;
      ST_START2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      ST_DIV2: cmd.cap_lvl = sts.div_done;
      ST_EMIT: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/gmd_dp.sv =====
// Datapath: config registers, channel measure, cell sum, sum store,
// divider and output register. Uses gmd_pkg and gmd_div.
`include "assert_macros.svh"
module gmd_dp
  import gmd_pkg::*;
#(
  parameter int CELLS           = 1024,
  parameter int CHROMA_UNSIGNED = 0,
  parameter int SUM_WIDTH       = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic [1:0]       in_tuser,
  input  gmd_cmd_t         cmd,
  output gmd_sts_t         sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SW = SUM_WIDTH;
  localparam int DW = SUM_WIDTH + 1;

  // configuration
  logic [2:0]       meas_mode_r;
  logic [7:0]       thresh_r;
  logic [PTS_W-1:0] points_r;
  logic [1:0]       reg_mode_r;
  logic [10:0]      col_lo_r, col_hi_r, row_lo_r, row_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_mode_r <= MEAS_Y;
      thresh_r    <= '0;
      points_r    <= PTS_W'(1);
      reg_mode_r  <= REGION_ALL;
      col_lo_r    <= '0;
      col_hi_r    <= '0;
      row_lo_r    <= '0;
      row_hi_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MEASURE_MODE: meas_mode_r <= cfg_wdata[2:0];
        REG_THRESHOLD:    thresh_r    <= cfg_wdata[7:0];
        REG_POINTS:       points_r    <= cfg_wdata[PTS_W-1:0];
        REG_REGION_MODE:  reg_mode_r  <= cfg_wdata[1:0];
        REG_COL_LO:       col_lo_r    <= cfg_wdata[10:0];
        REG_COL_HI:       col_hi_r    <= cfg_wdata[10:0];
        REG_ROW_LO:       row_lo_r    <= cfg_wdata[10:0];
        REG_ROW_HI:       row_hi_r    <= cfg_wdata[10:0];
        default:          thresh_r    <= thresh_r;
      endcase
    end
  end

  // input fields
  logic [7:0]       px_y, px_u, px_v;
  logic [IDX_W-1:0] px_col, px_row, px_idx;
  assign px_y   = in_tdata[7:0];
  assign px_u   = in_tdata[15:8];
  assign px_v   = in_tdata[23:16];
  assign px_col = in_tdata[33:24];
  assign px_row = in_tdata[43:34];
  assign px_idx = in_tdata[53:44];

  // channel measure
  logic [8:0]         u_raw, v_raw;
  logic signed [8:0]  u_s, v_s;
  logic signed [24:0] y_sh, t_r, t_g, t_b;
  logic signed [8:0]  r_ch, g_ch, b_ch, meas;

  function automatic logic signed [8:0] clip_px(input logic signed [24:0] t);
    logic signed [12:0] q;
    q = t[24:12];
    if (q < 13'sd0) begin
      clip_px = 9'sd0;
    end else if (q > PIX_MAX) begin
      clip_px = 9'sd255;
    end else begin
      clip_px = $signed({1'b0, q[7:0]});
    end
  endfunction

  always_comb begin
    if (CHROMA_UNSIGNED != 0) begin
      u_raw = {1'b0, px_u} - CHROMA_OFS;
      v_raw = {1'b0, px_v} - CHROMA_OFS;
    end else begin
      u_raw = {px_u[7], px_u};
      v_raw = {px_v[7], px_v};
    end
    u_s  = $signed(u_raw);
    v_s  = $signed(v_raw);
    y_sh = $signed({5'b00000, px_y, 12'h000});
    t_r  = y_sh + 25'(v_s * COEF_RV) + ROUND_HALF;
    t_g  = y_sh - 25'(u_s * COEF_GU) - 25'(v_s * COEF_GV) + ROUND_HALF;
    t_b  = y_sh + 25'(u_s * COEF_BU) + ROUND_HALF;
    r_ch = clip_px(t_r);
    g_ch = clip_px(t_g);
    b_ch = clip_px(t_b);
    case (meas_mode_r)
      MEAS_U:  meas = u_s;
      MEAS_V:  meas = v_s;
      MEAS_R:  meas = r_ch;
      MEAS_G:  meas = g_ch;
      MEAS_B:  meas = b_ch;
      default: meas = $signed({1'b0, px_y});
    endcase
  end

  // region test, bounds swapped when reversed
  logic [10:0] clo, chi, rlo, rhi, col1, row1;
  logic        in_region, inc;
  always_comb begin
    clo       = (col_lo_r > col_hi_r) ? col_hi_r : col_lo_r;
    chi       = (col_lo_r > col_hi_r) ? col_lo_r : col_hi_r;
    rlo       = (row_lo_r > row_hi_r) ? row_hi_r : row_lo_r;
    rhi       = (row_lo_r > row_hi_r) ? row_lo_r : row_hi_r;
    col1      = {1'b0, px_col} + 11'd1;
    row1      = {1'b0, px_row} + 11'd1;
    in_region = (col1 >= clo) && (col1 <= chi) && (row1 >= rlo) && (row1 <= rhi);
    case (reg_mode_r)
      REGION_INSIDE:  inc = in_region;
      REGION_OUTSIDE: inc = !in_region;
      default:        inc = 1'b1;
    endcase
  end

  // pixel stage and cell sum
  logic signed [8:0] meas_r;
  logic              inc_r, pend_r, armed_r, fend_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SW-1:0]     sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      pend_r <= cmd.take;
      if (cmd.prep) begin
        sum_r <= '0;
      end else if (pend_r && inc_r) begin
        sum_r <= sum_r + SW'(meas_r);
      end
    end
    if (cmd.take) begin
      meas_r  <= meas;
      inc_r   <= inc;
      idx_r   <= px_idx;
      fend_r  <= in_tuser[0];
      armed_r <= in_tuser[1];
    end
  end

  // previous-frame sum store with clearing sweep after reset
  logic [SW-1:0] mem [CELLS];
  logic [SW-1:0] rd_q;
  logic [AW-1:0] clr_cnt_r, wr_addr, cell_addr;
  logic          in_rng, wr_en;
  logic [SW-1:0] curr, prev, wr_data;

  assign cell_addr = AW'(idx_r);
  assign in_rng    = (32'(idx_r) < CELLS);
  assign curr      = inc_r ? sum_r : '0;
  assign prev      = in_rng ? rd_q : '0;
  assign wr_en     = cmd.clr_en || (cmd.prep && in_rng);
  assign wr_addr   = cmd.clr_en ? clr_cnt_r : cell_addr;
  assign wr_data   = cmd.clr_en ? '0 : curr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.fetch) rd_q <= mem[cell_addr];
  end

  // divider operands
  logic [DW-1:0]    delta, mag1, mag2, cext, dividend, quo;
  logic [SW-1:0]    curr_r;
  logic [PTS_W-1:0] pts;
  logic             div_busy, div_done;

  assign delta    = {curr[SW-1], curr} - {prev[SW-1], prev};
  assign mag1     = delta[DW-1] ? DW'(0) - delta : delta;
  assign cext     = {curr_r[SW-1], curr_r};
  assign mag2     = cext[DW-1] ? DW'(0) - cext : cext;
  assign dividend = cmd.div_sel ? mag2 : mag1;
  assign pts      = (points_r == '0) ? PTS_W'(1) : points_r;

  always_ff @(posedge clk) begin
    if (cmd.prep) curr_r <= curr;
  end

  gmd_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (pts),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  logic [7:0] diff_r;
  logic [8:0] lvl_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_diff) begin
      diff_r <= (quo > DW'(255)) ? 8'd255 : quo[7:0];
    end
    if (cmd.cap_lvl) begin
      if (curr_r[SW-1]) begin
        lvl_r <= (quo > DW'(256)) ? 9'h100 : 9'(9'd0 - quo[8:0]);
      end else begin
        lvl_r <= (quo > DW'(255)) ? 9'd255 : {1'b0, quo[7:0]};
      end
    end
  end

  // result and frame state
  logic             moved, found;
  logic [CNT_W-1:0] cnt_r, cnt_inc;
  logic             primed_r, out_valid_r, out_last_r;
  logic [OUT_W-1:0] out_data_r;

  assign moved   = inc_r && (diff_r > thresh_r) && armed_r;
  assign cnt_inc = (moved && cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
  assign found   = fend_r && primed_r && armed_r && (cnt_inc != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        cnt_r       <= fend_r ? '0 : cnt_inc;
        primed_r    <= primed_r || fend_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.out_load) begin
      out_data_r <= {found, cnt_inc, moved,
                     inc_r ? lvl_r : 9'd0,
                     inc_r ? diff_r : 8'd0,
                     idx_r};
      out_last_r <= fend_r;
    end
  end

  assign sts.clr_done = cmd.clr_en && (clr_cnt_r == AW'(CELLS - 1));
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `GMD_ASSERT(a_div_idle_start, cmd.div_start |-> !div_busy, "divider started while busy")
  `GMD_ASSERT(a_out_no_overwrite, cmd.out_load |-> (!out_valid_r || out_tready), "result overwritten")
  `GMD_ASSERT_NEXT(a_div_done_after_busy, div_busy && !div_done, !cmd.take, "item taken during division")

endmodule

// ===== design/grid_cell_motion_detector_top.sv =====
// Grid cell motion detector: pixels in, one result per finished cell. A pixel that does not
// end its cell is accepted while the controller is idle, so such pixels stream at one per
// cycle. A pixel that ends a cell stalls the input through two passes of the bit-serial
// divider (difference mean, then level mean), plus any wait for the output to be taken.
// After reset the previous-sum store is cleared one entry a cycle, during which no pixel
// is taken; configuration writes are taken at any time.
// Depends on gmd_pkg, gmd_ctrl and gmd_dp.
module grid_cell_motion_detector_top
  import gmd_pkg::*;
#(
  parameter int CELLS           = 1024,
  parameter int CHROMA_UNSIGNED = 0,
  parameter int SUM_WIDTH       = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // luma[7:0], chroma_u[15:8], chroma_v[23:16], cell_column[33:24],
  // cell_row[43:34], cell_index[53:44], zero fill [55:54]
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tlast,   // last_in_cell
  // last_in_frame[0], trigger_armed[1]
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_cell[9:0], cell_diff[17:10], cell_level[26:18], cell_moved[27],
  // moved_count[38:28], motion_found[39]
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast   // frame_done
);

  gmd_cmd_t cmd;
  gmd_sts_t sts;

  gmd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_cell_end (in_tlast || in_tuser[0]),
    .in_tready   (in_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  gmd_dp #(
    .CELLS           (CELLS),
    .CHROMA_UNSIGNED (CHROMA_UNSIGNED),
    .SUM_WIDTH       (SUM_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sim/motion_checker.sv =====
// Checker for the grid cell motion detector: watches the pixel and result streams,
// predicts each cell result from its own copy of the state and compares field by field.
// Depends on gmd_pkg; configuration is seen on the cfg_ port.
`timescale 1ns / 100ps
module motion_checker
  import gmd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tlast,
  input  logic [1:0]       in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tlast,
  output int               fail_count,
  output int               cells_pending
);
  localparam int NCELLS = 1024;

  typedef struct packed {
    logic        found;
    logic [10:0] count;
    logic        moved;
    logic [8:0]  level;
    logic [7:0]  diff;
    logic [9:0]  cell_no;
  } cell_result_t;

  typedef struct {
    cell_result_t r;
    logic         frame_end;
  } cell_expect_t;

  logic [2:0]  meas_mode;
  logic [7:0]  thresh;
  logic [20:0] npoints;
  logic [1:0]  reg_mode;
  logic [10:0] col_lo, col_hi, row_lo, row_hi;

  logic signed [31:0] stored_sum [NCELLS];
  logic signed [31:0] run_sum;
  logic [10:0] moved_cnt;
  logic        primed;
  cell_expect_t cell_queue[$];

  assign cells_pending = cell_queue.size();

  function automatic int chroma_of(logic [7:0] b);
    return int'(signed'(b));
  endfunction

  function automatic int clip8(int t);
    int q;
    q = (t >= 0) ? t / 4096 : -((-t + 4095) / 4096);
    if (q < 0) return 0;
    if (q > 255) return 255;
    return q;
  endfunction

  function automatic int channel_value(logic [7:0] y8, logic [7:0] u8, logic [7:0] v8);
    int y, u, v;
    y = int'(y8);
    u = chroma_of(u8);
    v = chroma_of(v8);
    case (meas_mode)
      MEAS_U: return u;
      MEAS_V: return v;
      MEAS_R: return clip8(y * 4096 + v * int'(COEF_RV) + 2048);
      MEAS_G: return clip8(y * 4096 - u * int'(COEF_GU) - v * int'(COEF_GV) + 2048);
      MEAS_B: return clip8(y * 4096 + u * int'(COEF_BU) + 2048);
      default: return y;
    endcase
  endfunction

  function automatic bit cell_counted(logic [9:0] col, logic [9:0] row);
    int clo, chi, rlo, rhi, c, r;
    bit in_box;
    clo = (col_lo < col_hi) ? col_lo : col_hi;
    chi = (col_lo < col_hi) ? col_hi : col_lo;
    rlo = (row_lo < row_hi) ? row_lo : row_hi;
    rhi = (row_lo < row_hi) ? row_hi : row_lo;
    c = int'(col) + 1;
    r = int'(row) + 1;
    in_box = c >= clo && c <= chi && r >= rlo && r <= rhi;
    if (reg_mode == REGION_INSIDE) return in_box;
    if (reg_mode == REGION_OUTSIDE) return !in_box;
    return 1'b1;
  endfunction

  task automatic accumulate_pixel(logic [IN_W-1:0] d, logic lic, logic [1:0] u);
    logic [9:0] col, row, idx;
    bit inc, cell_end, frame_end, armed;
    longint pts, curr, prev, dd, lvl;
    cell_expect_t e;
    col = d[33:24];
    row = d[43:34];
    idx = d[53:44];
    frame_end = u[0];
    armed = u[1];
    cell_end = lic || frame_end;
    inc = cell_counted(col, row);
    if (inc) run_sum = run_sum + channel_value(d[7:0], d[15:8], d[23:16]);
    if (!cell_end) return;
    pts = (npoints == 0) ? 1 : longint'(npoints);
    curr = inc ? longint'(run_sum) : 0;
    prev = longint'(stored_sum[idx]);
    e.r = '0;
    e.r.cell_no = idx;
    if (inc) begin
      dd = (curr - prev) / pts;
      if (dd < 0) dd = -dd;
      e.r.diff = (dd > 255) ? 8'd255 : dd[7:0];
      lvl = curr / pts;
      if (lvl > 255) lvl = 255;
      if (lvl < -256) lvl = -256;
      e.r.level = lvl[8:0];
      e.r.moved = (e.r.diff > thresh) && armed;
      if (e.r.moved && moved_cnt < CNT_MAX) moved_cnt++;
    end
    stored_sum[idx] = curr[31:0];
    run_sum = 0;
    e.r.count = moved_cnt;
    e.r.found = frame_end && primed && armed && moved_cnt != 0;
    e.frame_end = frame_end;
    cell_queue.push_back(e);
    if (frame_end) begin
      primed = 1'b1;
      moved_cnt = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      meas_mode <= MEAS_Y; thresh <= '0; npoints <= 21'd1; reg_mode <= REGION_ALL;
      col_lo <= '0; col_hi <= '0; row_lo <= '0; row_hi <= '0;
      for (int i = 0; i < NCELLS; i++) stored_sum[i] = '0;
      run_sum = '0; moved_cnt = '0; primed = 1'b0;
      fail_count <= 0;
      cell_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MEASURE_MODE: meas_mode <= cfg_wdata[2:0];
          REG_THRESHOLD:    thresh <= cfg_wdata[7:0];
          REG_POINTS:       npoints <= cfg_wdata[20:0];
          REG_REGION_MODE:  reg_mode <= cfg_wdata[1:0];
          REG_COL_LO:       col_lo <= cfg_wdata[10:0];
          REG_COL_HI:       col_hi <= cfg_wdata[10:0];
          REG_ROW_LO:       row_lo <= cfg_wdata[10:0];
          REG_ROW_HI:       row_hi <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) accumulate_pixel(in_tdata, in_tlast, in_tuser);
      if (out_tvalid && out_tready) begin
        if (cell_queue.size() == 0) begin
          $display("%0t: unexpected result, actual %h last %b", $time, out_tdata, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          cell_expect_t e;
          e = cell_queue.pop_front();
          if (out_tdata !== OUT_W'(e.r) || out_tlast !== e.frame_end) begin
            $display("%0t: cell %0d mismatch, expected %h last %b, actual %h last %b",
                     $time, e.r.cell_no, OUT_W'(e.r), e.frame_end, out_tdata, out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
// Top of the grid cell motion detector testbench: clock, reset, configuration phases
// and pixel stimulus with random gaps and stalls. Depends on gmd_pkg and motion_checker.
`timescale 1ns / 100ps
module testbench;
  import gmd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;
  int fail_count, cells_pending;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit hold_off = 1'b0;

  always #10 clk = ~clk;

  grid_cell_motion_detector_top u_dut (.*);
  motion_checker u_chk (.*);

  // receiver: random wait per item, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid) begin
      out_tready <= 1'b0;
      rx_wait <= $urandom_range(0, 11);
    end else if (!out_tready) begin
      if (rx_wait == 0) out_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("** grid_cell_motion_detector_top: FAILED **");
      $finish;
    end
  end

  // back-to-back writes keep the enable high; the next pixel drops it
  task automatic write_reg(logic [2:0] a, logic [CFG_W-1:0] d);
    cfg_we <= 1'b1; cfg_addr <= a; cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                            logic [9:0] col, logic [9:0] row, logic [9:0] idx,
                            logic lic, logic lif, logic armed, bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, idx, row, col, v, u, y};
    in_tlast <= lic;
    in_tuser <= {armed, lif};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (cells_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // one frame of cols x rows cells, each cell of npix pixels
  task automatic send_frame(int cols, int rows, int npix, bit armed, bit no_gap);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        for (int p = 0; p < npix; p++) begin
          bit lc, lf;
          lc = (p == npix - 1);
          lf = lc && r == rows - 1 && c == cols - 1;
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 10'(c), 10'(r),
                     10'(r * cols + c), lc && !(lf && $urandom_range(0, 3) == 0), lf, armed,
                     no_gap);
        end
  endtask

  initial begin
    int sent;
    bit held;
    held = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: field extremes and special cases at reset settings
    send_pixel(8'hFF, 8'h80, 8'h7F, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 1'b0, 1'b1, 1'b0);
    send_pixel(8'h00, 8'h7F, 8'h80, 10'h000, 10'h000, 10'h000, 1'b0, 1'b1, 1'b0, 1'b0);
    drain();
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_MEASURE_MODE, CFG_W'(m));
      send_pixel(8'hFF, 8'h7F, 8'h80, 10'd1, 10'd2, 10'd5, 1'b0, 1'b0, 1'b1, 1'b0);
      send_pixel(8'h00, 8'h80, 8'h7F, 10'd1, 10'd2, 10'd5, 1'b1, 1'b0, 1'b1, 1'b0);
      drain();
    end
    write_reg(REG_POINTS, CFG_W'(0));
    write_reg(REG_REGION_MODE, CFG_W'(3));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 10'd3, 10'd3, 10'd9, 1'b1, 1'b1, 1'b1, 1'b0);
    drain();
    // reversed bounds, inside and outside, a large point count
    write_reg(REG_COL_LO, CFG_W'(3)); write_reg(REG_COL_HI, CFG_W'(1));
    write_reg(REG_ROW_LO, CFG_W'(1024)); write_reg(REG_ROW_HI, CFG_W'(2));
    write_reg(REG_REGION_MODE, CFG_W'(REGION_INSIDE));
    write_reg(REG_POINTS, CFG_W'(21'h100000));
    write_reg(REG_THRESHOLD, CFG_W'(255));
    send_frame(4, 3, 1, 1'b1, 1'b0);
    drain();
    write_reg(REG_REGION_MODE, CFG_W'(REGION_OUTSIDE));
    write_reg(REG_COL_LO, CFG_W'(0)); write_reg(REG_COL_HI, CFG_W'(1024));
    write_reg(REG_ROW_LO, CFG_W'(2)); write_reg(REG_ROW_HI, CFG_W'(2));
    send_frame(4, 3, 1, 1'b1, 1'b0);
    drain();
    // random frames with random settings
    sent = 0;
    while (sent < 1800) begin
      int cols, rows, npix;
      write_reg(REG_MEASURE_MODE, CFG_W'($urandom_range(0, 7)));
      write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 20)));
      npix = $urandom_range(1, 6);
      write_reg(REG_POINTS, CFG_W'($urandom_range(0, 4) == 0 ? $urandom : npix));
      write_reg(REG_REGION_MODE, CFG_W'($urandom_range(0, 3)));
      write_reg(REG_COL_LO, CFG_W'($urandom_range(0, 6)));
      write_reg(REG_COL_HI, CFG_W'($urandom_range(0, 6)));
      write_reg(REG_ROW_LO, CFG_W'($urandom_range(0, 5)));
      write_reg(REG_ROW_HI, CFG_W'($urandom_range(0, 5)));
      cols = $urandom_range(1, 5);
      rows = $urandom_range(1, 4);
      for (int f = 0; f < 3; f++) begin
        if (!held && sent >= 900 && f == 0) begin
          held = 1'b1;
          // hold the receiver off while pixels keep coming
          fork
            begin
              hold_off = 1'b1;
              repeat (400) @(posedge clk);
              hold_off = 1'b0;
            end
            send_frame(5, 4, npix, 1'b1, 1'b1);
          join
          sent += 20 * npix;
        end else begin
          send_frame(cols, rows, npix, $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0);
          sent += cols * rows * npix;
        end
      end
      drain();
    end
    if (fail_count == 0) $display("** grid_cell_motion_detector_top: PASSED **");
    else $display("** grid_cell_motion_detector_top: FAILED **");
    $finish;
  end
endmodule
